// ===== design/mavg_pkg.sv =====
`timescale 1ns / 1ps

package mavg_pkg;

    localparam int MAX_WINDOW     = 64;
    localparam int SAMPLE_W       = 16;
    localparam int WIN_W          = 7;
    localparam int PTR_W          = $clog2(MAX_WINDOW);
    localparam int SUM_W          = 23;
    localparam int DIV_STEPS      = SUM_W;
    localparam int CNT_W          = $clog2(DIV_STEPS + 1);
    localparam int RESET_WINDOW   = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic cfg_write;
        logic update;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic produce;
        logic div_last;
        logic out_free;
    } t_ctrl_sts;

    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] value);
        logic [WIN_W-1:0] result;
        result = value;
        if (value == '0) begin
            result = WIN_W'(1);
        end else if (value > WIN_W'(MAX_WINDOW)) begin
            result = WIN_W'(MAX_WINDOW);
        end
        return result;
    endfunction

endpackage

// ===== design/mavg_ctrl.sv =====
`timescale 1ns / 1ps

module mavg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  mavg_pkg::t_ctrl_sts i_sts,
    output mavg_pkg::t_ctrl_cmd o_cmd
);

    mavg_pkg::t_state r_state;
    mavg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mavg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        o_cfg_ready     = 1'b0;
        case (r_state)
            mavg_pkg::ST_IDLE: begin
                o_cfg_ready     = 1'b1;
                o_s_axis_tready = !i_cfg_valid;
                o_cmd.cfg_write = i_cfg_valid;
                if (i_s_axis_tvalid && !i_cfg_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = mavg_pkg::ST_UPDATE;
                end
            end
            mavg_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_sts.produce) begin
                    n_state = mavg_pkg::ST_DIVIDE;
                end else begin
                    n_state = mavg_pkg::ST_IDLE;
                end
            end
            mavg_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = mavg_pkg::ST_DONE;
                end
            end
            mavg_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mavg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mavg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mavg_datapath.sv =====
`timescale 1ns / 1ps

module mavg_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mavg_pkg::t_ctrl_cmd                 i_cmd,
    output mavg_pkg::t_ctrl_sts                 o_sts,
    input  logic [mavg_pkg::WIN_W-1:0]          i_cfg_data,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_first,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mavg_pkg::SAMPLE_W-1:0] o_average,
    output logic                                o_last
);

    localparam int SW = mavg_pkg::SAMPLE_W;
    localparam int SUMW = mavg_pkg::SUM_W;
    localparam int WW = mavg_pkg::WIN_W;
    localparam int PW = mavg_pkg::PTR_W;
    localparam int CW = mavg_pkg::CNT_W;

    logic [SW-1:0]          r_ring [mavg_pkg::MAX_WINDOW];
    logic [SW-1:0]          r_rd_data;
    logic [SW-1:0]          r_sample;
    logic                   r_last;
    logic [WW-1:0]          r_win;
    logic [WW-1:0]          r_fill;
    logic [PW-1:0]          r_wr_ptr;
    logic signed [SUMW-1:0] r_sum;
    logic [WW-1:0]          r_rem;
    logic [SUMW-1:0]        r_quo;
    logic                   r_neg;
    logic [CW-1:0]          r_cnt;
    logic                   r_m_valid;
    logic [SW-1:0]          r_avg;
    logic                   r_last_out;

    logic [PW-1:0]          rd_addr;
    logic                   full;
    logic [WW:0]            fill_inc;
    logic [WW-1:0]          ptr_inc;
    logic signed [SUMW-1:0] n_sum;
    logic [SUMW-1:0]        sum_mag;
    logic [WW+1:0]          trial;
    logic [SW-1:0]          quo_lo;

    assign rd_addr  = i_first ? '0 : r_wr_ptr;
    assign full     = (r_fill == r_win);
    assign fill_inc = {1'b0, r_fill} + (WW+1)'(1);
    assign ptr_inc  = {1'b0, r_wr_ptr} + WW'(1);
    assign n_sum    = r_sum
                    - (full ? {{(SUMW-SW){r_rd_data[SW-1]}}, r_rd_data} : SUMW'(0))
                    + {{(SUMW-SW){r_sample[SW-1]}}, r_sample};
    assign sum_mag  = n_sum[SUMW-1] ? SUMW'(-n_sum) : SUMW'(n_sum);
    assign trial    = {1'b0, r_rem, r_quo[SUMW-1]} - {2'b00, r_win};
    assign quo_lo   = r_quo[SW-1:0];

    assign o_sts.produce  = full || (fill_inc >= {1'b0, r_win});
    assign o_sts.div_last = (r_cnt == CW'(1));
    assign o_sts.out_free = !r_m_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_ring[rd_addr];
            r_sample  <= i_sample;
            r_last    <= i_last;
        end
        if (i_cmd.update) begin
            r_ring[r_wr_ptr] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= WW'(mavg_pkg::RESET_WINDOW);
            r_fill   <= '0;
            r_wr_ptr <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.cfg_write) begin
                r_win    <= mavg_pkg::eff_window(i_cfg_data);
                r_fill   <= '0;
                r_wr_ptr <= '0;
                r_sum    <= '0;
            end else if (i_cmd.accept && i_first) begin
                r_fill   <= '0;
                r_wr_ptr <= '0;
                r_sum    <= '0;
            end else if (i_cmd.update) begin
                r_sum    <= n_sum;
                r_wr_ptr <= (ptr_inc >= r_win) ? '0 : ptr_inc[PW-1:0];
                if (!full) begin
                    r_fill <= fill_inc[WW-1:0];
                end
            end
            if (i_cmd.update && o_sts.produce) begin
                r_cnt <= CW'(mavg_pkg::DIV_STEPS);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_neg <= n_sum[SUMW-1];
            r_quo <= sum_mag;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[WW+1]) begin
                r_rem <= trial[WW-1:0];
                r_quo <= {r_quo[SUMW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[WW-2:0], r_quo[SUMW-1]};
                r_quo <= {r_quo[SUMW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_avg      <= r_neg ? SW'(-quo_lo) : quo_lo;
            r_last_out <= r_last;
        end
    end

    assign o_valid   = r_m_valid;
    assign o_average = r_avg;
    assign o_last    = r_last_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_win)
        else $error("Fill count exceeds the window.");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_wr_ptr} < r_win)
        else $error("Write pointer is outside the window.");

    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_win != '0) && (r_win <= WW'(mavg_pkg::MAX_WINDOW)))
        else $error("Effective window is out of range.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> o_sts.out_free)
        else $error("Result loaded over an item not yet taken.");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt != '0))
        else $error("Divider stepped past its last quotient bit.");

endmodule

// ===== design/moving_average_filter_core.sv =====
`timescale 1ns / 1ps

// Boxcar moving average over signed Q8.8 samples, one item at a time. An accepted
// item first reads the oldest ring entry, then updates the running sum. When it
// yields a result, the restoring divider follows, producing one quotient bit per
// cycle, and then the output register is loaded once it is free. The output
// register lets the next item be accepted while a result waits downstream. A
// configuration write clears the window.
module moving_average_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // sample
    input  logic        i_s_axis_tuser,  // first_sample
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // average
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    mavg_pkg::t_ctrl_cmd cmd;
    mavg_pkg::t_ctrl_sts sts;
    logic signed [mavg_pkg::SAMPLE_W-1:0] average;

    mavg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    mavg_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_s_axis_tdata),
        .i_first    (i_s_axis_tuser),
        .i_last     (i_s_axis_tlast),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_average  (average),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = average;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int SAMPLE_W       = mavg_pkg::SAMPLE_W;
    localparam int MAX_WINDOW     = mavg_pkg::MAX_WINDOW;
    localparam int WIN_W          = mavg_pkg::WIN_W;
    localparam int RESET_WINDOW   = mavg_pkg::RESET_WINDOW;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 1950;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       first;
        logic                       last;
    } t_sample_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       last;
    } t_avg_result;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [15:0]         i_s_axis_tdata = '0;
    logic                i_s_axis_tuser = 1'b0;
    logic                i_s_axis_tlast = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [15:0]         o_m_axis_tdata;
    logic                o_m_axis_tlast;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [WIN_W-1:0]    i_cfg_data = '0;

    moving_average_filter_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sample_item sample_q[$];
    t_avg_result  average_q[$];

    logic signed [SAMPLE_W-1:0] ring_copy [MAX_WINDOW];
    int          window_sum;
    int unsigned fill_level;
    int unsigned write_slot;
    logic [WIN_W-1:0] window_reg = WIN_W'(RESET_WINDOW);

    int errors = 0;
    int samples_sent = 0;
    int averages_checked = 0;
    int config_writes = 0;
    bit hold_request = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic void clear_window();
        window_sum = 0;
        fill_level = 0;
        write_slot = 0;
    endfunction

    function automatic int unsigned active_window();
        if (window_reg == '0) begin
            return 1;
        end
        if (window_reg > WIN_W'(MAX_WINDOW)) begin
            return MAX_WINDOW;
        end
        return 32'(window_reg);
    endfunction

    function automatic void take_sample(input t_sample_item it);
        int unsigned w;
        int unsigned slot;
        t_avg_result res;
        if (it.first) begin
            clear_window();
        end
        w = active_window();
        if (fill_level > w) begin
            clear_window();
        end
        if (write_slot >= w) begin
            write_slot = 0;
        end
        slot = write_slot;
        if (fill_level == w) begin
            window_sum -= int'(ring_copy[slot]);
        end
        ring_copy[slot] = it.value;
        window_sum += int'(it.value);
        write_slot = (slot + 1 >= w) ? 0 : slot + 1;
        if (fill_level < w) begin
            fill_level++;
        end
        if (fill_level == w) begin
            res.average = SAMPLE_W'(window_sum / int'(w));
            res.last = it.last;
            average_q.push_back(res);
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    t_sample_item cur_item;
    bit offering = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                take_sample(cur_item);
                samples_sent++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_q.size() > 0) begin
                    cur_item = sample_q.pop_front();
                    offering = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                    end
                end
            end
            i_s_axis_tvalid <= offering;
            i_s_axis_tdata  <= cur_item.value;
            i_s_axis_tuser  <= cur_item.first;
            i_s_axis_tlast  <= cur_item.last;
        end
    end

    // Receiver: stall pattern switching between modes, plus one long hold-off.
    t_rx_mode rx_mode = RX_FREE;
    int pattern_left = 0;
    int hold_left = 0;
    bit hold_taken = 1'b0;
    bit next_ready;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 2));
                    pattern_left = $urandom_range(50, 300);
                end
                pattern_left--;
                case (rx_mode)
                    RX_FREE: begin
                        next_ready = 1'b1;
                    end
                    RX_COIN: begin
                        next_ready = ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        next_ready = ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
            i_m_axis_tready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (average_q.size() == 0) begin
                report_mismatch("unexpected average", int'($signed(o_m_axis_tdata)), 0);
            end else begin
                want = average_q.pop_front();
                if (o_m_axis_tdata !== want.average) begin
                    report_mismatch("average", int'($signed(o_m_axis_tdata)),
                                    int'(want.average));
                end
                if (o_m_axis_tlast !== want.last) begin
                    report_mismatch("last flag", int'(o_m_axis_tlast), int'(want.last));
                end
                averages_checked++;
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a handshake.", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic add_sample(input logic signed [SAMPLE_W-1:0] v, input logic f,
                              input logic l);
        t_sample_item it;
        it.value = v;
        it.first = f;
        it.last = l;
        sample_q.push_back(it);
    endtask

    // Mostly well-formed records of at least a window, some short ones and some noise.
    task automatic add_records(input int unsigned n_items, input int unsigned w);
        int unsigned made;
        int unsigned len;
        int unsigned k;
        int roll;
        made = 0;
        while (made < n_items) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    add_sample(pick_value(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end
            end else if (roll == 1 && w > 1) begin
                len = $urandom_range(1, w - 1);
                for (k = 0; k < len; k++) begin
                    add_sample(pick_value(), k == 0, k == len - 1);
                end
            end else begin
                len = w + $urandom_range(0, w + 12);
                for (k = 0; k < len; k++) begin
                    add_sample(pick_value(), k == 0, k == len - 1);
                end
            end
            made += len;
        end
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || offering || average_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_reg = v;
        clear_window();
        config_writes++;
    endtask

    logic [WIN_W-1:0] window_plan [10];
    int p;

    initial begin
        clear_window();
        window_plan = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65, 7'd2, 7'd3, 7'd4, 7'd9, 7'd30};
        window_plan[8] = WIN_W'($urandom_range(5, 20));
        window_plan[9] = WIN_W'($urandom_range(21, 63));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of four, no first mark after reset, full-scale values.
        repeat (4) add_sample(16'sh7FFF, 1'b0, 1'b0);
        repeat (3) add_sample(16'sh8000, 1'b0, 1'b0);
        add_sample(16'sh8000, 1'b0, 1'b1);
        // A record shorter than the window loses its last mark.
        add_sample(-16'sd1, 1'b1, 1'b0);
        add_sample(-16'sd2, 1'b0, 1'b0);
        add_sample(16'sd3, 1'b0, 1'b1);
        // Negative and positive sums that must truncate toward zero.
        add_sample(-16'sd1, 1'b1, 1'b0);
        add_sample(16'sd0, 1'b0, 1'b0);
        add_sample(-16'sd6, 1'b0, 1'b0);
        add_sample(16'sd0, 1'b0, 1'b1);
        add_sample(16'sd7, 1'b1, 1'b0);
        add_sample(16'sd0, 1'b0, 1'b0);
        add_sample(16'sd0, 1'b0, 1'b0);
        add_sample(16'sd2, 1'b0, 1'b0);
        add_sample(-16'sd32767, 1'b0, 1'b1);
        // Partial record that the next register write must discard.
        add_sample(16'sh7FFF, 1'b1, 1'b0);
        add_sample(16'sh7FFF, 1'b0, 1'b0);
        wait_drained();

        for (p = 0; p < 10; p++) begin
            write_window(window_plan[p]);
            if (p == 0) begin
                @(posedge i_clk);
                hold_request <= 1'b1;
            end
            add_records(RANDOM_ITEMS / 10, active_window());
            wait_drained();
        end

        $display("Sent %0d samples over %0d window settings; checked %0d averages.",
                 samples_sent, config_writes, averages_checked);
        $display("Windows written include 0, 1, 64 and the clamped 65 and 127.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
